### sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under active-low reset
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under active-low reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bba_pkg.sv
package bba_pkg;

    localparam int MAX_BLOCKS  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = $clog2(MAP_WORDS);
    localparam int BIT_AW      = $clog2(WORD_BITS);
    localparam int BLK_W       = 12;
    localparam int CNT_W       = 13;
    localparam int COUNT_RESET = 4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_RANGE       = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic read;
        logic finish_early;
        logic finish_scan;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic early_done;
        logic is_free;
        logic hit;
        logic last;
        logic out_free;
    } sts_t;

endpackage

### sv/bba_datapath.sv
module bba_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bba_pkg::cmd_t              cmd,
    output bba_pkg::sts_t              sts,
    input  logic                       in_opcode,
    input  logic [bba_pkg::BLK_W-1:0]  in_block,
    input  logic                       cfg_valid,
    input  logic [bba_pkg::CNT_W-1:0]  cfg_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bba_pkg::BLK_W-1:0]  out_block,
    output logic [1:0]                 out_status
);
    import bba_pkg::*;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     limit;
    logic                 op_reg;
    logic [BLK_W-1:0]     blk_reg;
    logic [WORD_AW-1:0]   addr_reg;
    logic [WORD_AW-1:0]   eval_reg;
    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_vld_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;
    logic [WORD_BITS-1:0] word_eff;
    logic [CNT_W-1:0]     eval_end;
    logic [BIT_AW-1:0]    tail;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_vec;
    logic [BIT_AW-1:0]    idx;
    logic                 hit;
    logic                 last;
    logic                 out_of_range;
    logic                 bit_used;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic [BLK_W-1:0]     res_block;
    status_t              res_status;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BLK_W-1:0]     out_block_reg;
    status_t              out_status_reg;
    logic                 finish;

    // block count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_W'(COUNT_RESET);
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    assign limit = (count_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_reg;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= in_opcode;
            blk_reg <= in_block;
        end
    end

    // read address and word under test
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            addr_reg <= (in_opcode == OP_FREE) ? in_block[BLK_W-1:BIT_AW] : '0;
        end else if (cmd.read) begin
            addr_reg <= addr_reg + WORD_AW'(1);
            eval_reg <= addr_reg;
        end
    end

    // bitmap memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_data_reg <= mem[addr_reg];
            rd_vld_reg  <= row_vld_reg[addr_reg];
        end
        if (wr_en) begin
            mem[eval_reg] <= wr_data;
        end
    end

    // row valid bits, unwritten rows read as all free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (wr_en) begin
            row_vld_reg[eval_reg] <= 1'b1;
        end
    end

    assign word_eff = rd_vld_reg ? rd_data_reg : '0;

    // bits of this word that lie below the limit
    assign eval_end = CNT_W'({eval_reg, BIT_AW'(0)}) + CNT_W'(WORD_BITS);
    assign last     = (eval_end >= limit);
    assign tail     = limit[BIT_AW-1:0];
    assign mask     = (last && (tail != '0)) ? ((WORD_BITS'(1) << tail) - WORD_BITS'(1)) : '1;
    assign free_vec = ~word_eff & mask;
    assign hit      = |free_vec;

    // lowest free bit
    always_comb begin
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                idx = BIT_AW'(i);
            end
        end
    end

    assign out_of_range = ({1'b0, blk_reg} >= limit);
    assign bit_used     = word_eff[blk_reg[BIT_AW-1:0]];

    // result and write-back
    always_comb begin
        wr_en      = 1'b0;
        wr_data    = word_eff;
        res_block  = '0;
        res_status = ST_OK;
        if (cmd.finish_early) begin
            res_status = (op_reg == OP_FREE) ? ST_RANGE : ST_FULL;
        end else if (op_reg == OP_FREE) begin
            if (bit_used) begin
                wr_en   = cmd.finish_scan;
                wr_data = word_eff & ~(WORD_BITS'(1) << blk_reg[BIT_AW-1:0]);
            end else begin
                res_status = ST_DOUBLE_FREE;
            end
        end else if (hit) begin
            wr_en     = cmd.finish_scan;
            wr_data   = word_eff | (WORD_BITS'(1) << idx);
            res_block = {eval_reg, idx};
        end else begin
            res_status = ST_FULL;
        end
    end

    assign finish = cmd.finish_early | cmd.finish_scan;

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (finish) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            out_block_reg  <= res_block;
            out_status_reg <= res_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_block  = out_block_reg;
    assign out_status = out_status_reg;

    // status to controller
    assign sts.early_done = (op_reg == OP_FREE) ? out_of_range : (limit == '0);
    assign sts.is_free    = (op_reg == OP_FREE);
    assign sts.hit        = hit;
    assign sts.last       = last;
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule

### sv/bba_ctrl.sv
module bba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_SCAN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   scan_end;

    // a free ends on its one word, an allocate on a hit or the last word
    assign scan_end = sts.is_free || sts.hit || sts.last;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                if (sts.early_done) begin
                    if (sts.out_free) begin
                        cmd.finish_early = 1'b1;
                        state_next       = S_IDLE;
                    end
                end else begin
                    cmd.read   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    if (sts.out_free) begin
                        cmd.finish_scan = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.read = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/block_bitmap_allocator_top.sv
// channel   | direction | handshake          | contents
// s_        | in        | s_tvalid/s_tready  | tuser: opcode; tdata: block_number
// m_        | out       | m_tvalid/m_tready  | tdata: allocated_block, status
// cfg_      | in        | cfg_valid/cfg_ready| block_count
//
// a free reads only the word that holds its block; an allocate scans from word 0
// up to its first hit or the last word under min(count, 4096), through the one-word
// read port of the bitmap memory, which the scan walks one word per cycle.
// a free out of range, or an allocate at a count of 0, ends without reading the bitmap.
// reset marks every block free at once through per-row valid bits, no clearing pass.
// a finished result waits in the output register; the block stalls at its
// next finish only while that register is still full.
module block_bitmap_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] block_number, [15:12] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] allocated_block, [13:12] status, [15:14] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);
    import bba_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic [BLK_W-1:0] out_block;
    logic [1:0]       out_status;

    // control
    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // bitmap and result path
    bba_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_opcode  (s_tuser[0]),
        .in_block   (s_tdata[BLK_W-1:0]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_block  (out_block),
        .out_status (out_status)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {2'b00, out_status, out_block};

endmodule

### sv/bba_checker.sv
`include "assert_macros.svh"

module bba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import bba_pkg::*;

    logic        s_accept;
    logic        stalled;
    logic        err_word;
    logic [1:0]  res_status;
    logic [11:0] res_block;

    assign s_accept   = s_tvalid && s_tready;
    assign stalled    = m_tvalid && !m_tready;
    assign res_status = m_tdata[13:12];
    assign res_block  = m_tdata[11:0];
    assign err_word   = m_tvalid && (res_status != ST_OK);

    // stalled word holds
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, stalled, m_tvalid, "m_tvalid dropped")
    `ASSERT_NEXT(a_hold_data, aclk, aresetn, stalled, $stable(m_tdata), "m_tdata changed")

    // busy right after a word is taken
    `ASSERT_NEXT(a_busy, aclk, aresetn, s_accept, !s_tready, "took two words in a row")

    // failed requests return block zero
    `ASSERT_SAME(a_zero_block, aclk, aresetn, err_word, res_block == '0, "block set on error")

    // pad bits stay clear
    `ASSERT_SAME(a_pad, aclk, aresetn, m_tvalid, m_tdata[15:14] == 2'b00, "pad bits set")

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (.*);

### test/tb.sv
`timescale 1ns / 100ps

module tb;
    import bba_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 14;

    typedef struct packed {
        logic             op;
        logic [BLK_W-1:0] blk;
    } request_t;

    typedef struct packed {
        status_t          status;
        logic [BLK_W-1:0] block;
    } grant_t;

    typedef struct packed {
        logic [MAX_BLOCKS-1:0] used;
        logic [CNT_W-1:0]      count;
    } alloc_map_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [11:0] block_number, [15:12] zero
    logic [0:0]  s_tuser   = '0;   // [0] opcode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [11:0] allocated_block, [13:12] status, [15:14] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data  = '0;

    // bitmap as seen by the stimulus planner and by the checker
    alloc_map_t plan_map;
    alloc_map_t live_map;

    request_t request_q[$];
    grant_t   grant_q[$];

    int n_queued       = 0;
    int n_checked      = 0;
    int n_errors       = 0;
    int n_settings     = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    block_bitmap_allocator_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #10 aclk = ~aclk;

    // first-fit allocate or free on a bitmap, returns the grant word
    function automatic grant_t serve_request(inout alloc_map_t st, input request_t rq);
        grant_t g;
        int     limit;
        int     n;
        limit    = (int'(st.count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(st.count);
        g.block  = '0;
        g.status = ST_FULL;
        if (rq.op == OP_ALLOC) begin
            for (n = 0; n < limit; n++) begin
                if (!st.used[n]) begin
                    st.used[n] = 1'b1;
                    g.block    = BLK_W'(n);
                    g.status   = ST_OK;
                    break;
                end
            end
        end else if (int'(rq.blk) >= limit) begin
            g.status = ST_RANGE;
        end else if (!st.used[rq.blk]) begin
            g.status = ST_DOUBLE_FREE;
        end else begin
            st.used[rq.blk] = 1'b0;
            g.status        = ST_OK;
        end
        return g;
    endfunction

    // request driver, expectation computed on acceptance
    always @(posedge aclk) begin
        request_t rq;
        request_t seen;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                seen.op  = s_tuser[0];
                seen.blk = s_tdata[BLK_W-1:0];
                grant_q.push_back(serve_request(live_map, seen));
            end
            if (!s_tvalid || s_tready) begin
                if (request_q.size() > 0 && $urandom_range(99) >= src_gap_pct) begin
                    rq = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= rq.op;
                    s_tdata  <= {4'b0000, rq.blk};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and comparison
    always @(posedge aclk) begin
        grant_t want;
        grant_t got;
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.block  = m_tdata[BLK_W-1:0];
            got.status = status_t'(m_tdata[13:12]);
            n_checked <= n_checked + 1;
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected word, block %0d status %0d",
                         $time, got.block, got.status);
                n_errors = n_errors + 1;
            end else begin
                want = grant_q.pop_front();
                status_seen[int'(want.status)]++;
                if (got.block !== want.block) begin
                    $display("%0t: allocated_block expected %0d actual %0d",
                             $time, want.block, got.block);
                    n_errors = n_errors + 1;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_req(input logic op, input logic [BLK_W-1:0] blk);
        request_t rq;
        rq.op  = op;
        rq.blk = blk;
        void'(serve_request(plan_map, rq));
        request_q.push_back(rq);
        n_queued++;
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (n_checked != n_queued);
    endtask

    task automatic write_block_count(input logic [CNT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        plan_map.count = value;
        live_map.count = value;
        n_settings++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_gap_pct = 50; sink_stall_pct = 0;  end
            2: begin src_gap_pct = 0;  sink_stall_pct = 50; end
            default: begin src_gap_pct = 18; sink_stall_pct = 18; end
        endcase
    endtask

    // mostly allocs and frees of blocks in use, some stray frees
    task automatic run_phase(input int items);
        int               lim;
        int               alloc_pct;
        int               pick;
        int               n;
        int               k;
        logic [BLK_W-1:0] blk;
        lim       = (int'(plan_map.count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(plan_map.count);
        alloc_pct = $urandom_range(75, 40);
        repeat (items) begin
            pick = $urandom_range(99);
            blk  = BLK_W'($urandom);
            if (pick < alloc_pct) begin
                put_req(OP_ALLOC, blk);
            end else begin
                if (lim > 0 && pick < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
                    // find a used block from a random start
                    n = $urandom_range(lim - 1);
                    for (k = 0; k < lim && !plan_map.used[n]; k++)
                        n = (n + 1) % lim;
                    blk = BLK_W'(n);
                end else if (pick[0] && lim > 0 && lim < MAX_BLOCKS) begin
                    // right at or just past the end of the managed range
                    blk = BLK_W'(lim + $urandom_range(2));
                end
                put_req(OP_FREE, blk);
            end
        end
    endtask

    initial begin
        int counts[PHASES];
        int p;
        counts = '{4096, 40, 8191, 0, 17, 64, 10, 64, 1, 4097, 33, 2, 100, 4096};
        plan_map.used  = '0;
        plan_map.count = CNT_W'(COUNT_RESET);
        live_map       = plan_map;
        set_idling(0);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: first fit, reuse, double free, top block
        put_req(OP_ALLOC, 12'hFFF);
        put_req(OP_ALLOC, 12'h000);
        put_req(OP_FREE,  12'h000);
        put_req(OP_FREE,  12'h000);
        put_req(OP_FREE,  12'hFFF);
        put_req(OP_ALLOC, 12'h555);
        put_req(OP_ALLOC, 12'hAAA);
        put_req(OP_FREE,  12'h001);
        // empty bitmap range
        write_block_count(13'd0);
        put_req(OP_ALLOC, 12'h000);
        put_req(OP_FREE,  12'h000);
        put_req(OP_FREE,  12'hFFF);
        // count above capacity clips to full size
        write_block_count(13'h1FFF);
        put_req(OP_FREE,  12'hFFF);
        put_req(OP_ALLOC, 12'h000);
        // lowered count strands blocks above it
        write_block_count(13'd1);
        put_req(OP_ALLOC, 12'h000);
        put_req(OP_FREE,  12'h002);
        put_req(OP_FREE,  12'h000);
        put_req(OP_ALLOC, 12'h000);
        put_req(OP_ALLOC, 12'h000);
        // raised again, stranded blocks come back
        write_block_count(13'd4097);
        put_req(OP_FREE,  12'h002);
        put_req(OP_FREE,  12'h001);
        put_req(OP_FREE,  12'h000);

        // random phases over several counts and idling patterns
        for (p = 0; p < PHASES; p++) begin
            write_block_count(CNT_W'(counts[p]));
            set_idling(p % 4);
            if (p == 5) begin
                run_phase(33);
                wait_drained();
                run_phase(34);
            end else begin
                run_phase(67);
            end
        end

        wait_drained();
        repeat (150) @(posedge aclk);
        if (grant_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, grant_q.size());
            n_errors = n_errors + 1;
        end

        $display("checked %0d words over %0d block count settings", n_checked, n_settings);
        $display("ok %0d, out of blocks %0d, double free %0d, out of range %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
